[hdl/pdm_pkg.sv]
// ---------------------------------------------------------------------------
// pdm_pkg: shared types and constants
// Register map, field widths and the gain/speed register bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package pdm_pkg;

  localparam int GAIN_W  = 24;
  localparam int SPEED_W = 7;
  localparam int SUM_W   = 40;
  localparam int RAW_W   = 32;
  localparam int CFG_AW  = 3;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_AW-1:0] {
    REG_GAIN_PROP     = 3'd0,
    REG_GAIN_INTEGRAL = 3'd1,
    REG_GAIN_DERIV    = 3'd2,
    REG_SPEED_CEILING = 3'd3,
    REG_SPEED_FLOOR   = 3'd4
  } reg_idx_t;

  // Reset values: about 1.01, 0.18 * 0.01 and 0.09 / 0.01 in Q8.16
  localparam logic [GAIN_W-1:0]  GAIN_PROP_RST     = 24'd66191;
  localparam logic [GAIN_W-1:0]  GAIN_INTEGRAL_RST = 24'd118;
  localparam logic [GAIN_W-1:0]  GAIN_DERIV_RST    = 24'd589824;
  localparam logic [SPEED_W-1:0] SPEED_CEILING_RST = 7'd90;
  localparam logic [SPEED_W-1:0] SPEED_FLOOR_RST   = 7'd10;

  // Saturation bounds
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [63:0]      U_MAX   = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0]      U_MIN   = {1'b1, {63{1'b0}}};
  localparam logic [RAW_W-1:0]        RAW_MAX = {1'b0, {(RAW_W-1){1'b1}}};
  localparam logic [RAW_W-1:0]        RAW_MIN = {1'b1, {(RAW_W-1){1'b0}}};

  // Gain and speed limit registers as seen by the datapath
  typedef struct packed {
    logic [GAIN_W-1:0]  gain_prop;
    logic [GAIN_W-1:0]  gain_integral_step;
    logic [GAIN_W-1:0]  gain_deriv_step;
    logic [SPEED_W-1:0] speed_ceiling;
    logic [SPEED_W-1:0] speed_floor;
  } cfg_t;

endpackage

`default_nettype wire

[hdl/pid_position_motor_drive.sv]
// ---------------------------------------------------------------------------
// pid_position_motor_drive: PID position controller with speed clamp
// Error, saturating error sum, Q8.16 PID sum, direction and clamped speed.
// ---------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                  | tuser
//  --------+-----+-------------------------------------+----------------
//  in_     | in  | target_pos[15:0], measured_pos[31:16] | clear_history
//  out_    | out | speed_cmd[6:0], raw_output[38:7], 0   | drive_forward
//  cfg_    | in  | cfg_addr = register index, cfg_data = value (always ready)
//
//  Six register stages: input, error/sum, products, partial sums, saturated
//  output, result. One request per cycle is taken unless all stages are full
//  and the result is stalled.
//  Each stage moves on when the stage after it is empty or moving, so
//  bubbles are squeezed out and input is taken while a result waits.
//  The error sum and previous error update as a request leaves the input
//  stage. Reset (rst_n low, synchronous) empties the pipe and clears history.
//
`default_nettype none

module pid_position_motor_drive #(
  parameter int POS_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input requests
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [31:0]                 in_tdata,   // target_pos, measured_pos
  input  wire logic                        in_tuser,   // clear_history
  // results
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [39:0]                      out_tdata,  // speed_cmd, raw_output, pad
  output logic                             out_tuser,  // drive_forward
  // configuration writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [pdm_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [pdm_pkg::GAIN_W-1:0]  cfg_data
);
  import pdm_pkg::*;

  // Positions are 16-bit fields; only the low POS_BITS of them count
  localparam int PB     = (POS_BITS < 16) ? POS_BITS : 16;
  localparam int ERR_W  = PB + 1;
  localparam int DERR_W = PB + 2;
  localparam int P_W    = GAIN_W + 1 + ERR_W;
  localparam int D_W    = GAIN_W + 1 + DERR_W;
  localparam int HALF_W = SUM_W / 2;
  localparam int ILO_W  = GAIN_W + HALF_W;
  localparam int IHI_W  = GAIN_W + 1 + (SUM_W - HALF_W);
  localparam int ACC_W  = 66;

  cfg_t cfg;

  pdm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage valids and load enables
  logic [5:0] vld_r;
  logic [5:0] go;

  always_comb begin
    go[5] = !vld_r[5] || out_tready;
    for (int k = 4; k >= 0; k--) begin
      go[k] = !vld_r[k] || go[k+1];
    end
  end

  assign in_tready = go[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (go[0]) vld_r[0] <= in_tvalid;
      for (int k = 1; k < 6; k++) begin
        if (go[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage 0: input register
  logic [PB-1:0] tgt_r;
  logic [PB-1:0] meas_r;
  logic          clr_r;

  always_ff @(posedge clk) begin
    if (go[0]) begin
      tgt_r  <= in_tdata[PB-1:0];
      meas_r <= in_tdata[16 +: PB];
      clr_r  <= in_tuser;
    end
  end

  // Stage 1: error, saturating sum, error difference; history update
  logic signed [SUM_W-1:0]  error_sum_r;
  logic signed [ERR_W-1:0]  last_err_r;
  logic signed [SUM_W-1:0]  sum_prev;
  logic signed [ERR_W-1:0]  err_prev;
  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [DERR_W-1:0] derr_nxt;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [DERR_W-1:0] derr_r;

  always_comb begin
    sum_prev = clr_r ? '0 : error_sum_r;
    err_prev = clr_r ? '0 : last_err_r;
    err_nxt  = $signed({1'b0, tgt_r}) - $signed({1'b0, meas_r});
    sum_wide = (SUM_W+1)'(sum_prev) + (SUM_W+1)'(err_nxt);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_nxt = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = sum_wide[SUM_W-1:0];
    end
    derr_nxt = DERR_W'(err_nxt) - DERR_W'(err_prev);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r <= '0;
      last_err_r  <= '0;
    end else if (go[1] && vld_r[0]) begin
      error_sum_r <= sum_nxt;
      last_err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go[1]) begin
      err_r  <= err_nxt;
      sum_r  <= sum_nxt;
      derr_r <= derr_nxt;
    end
  end

  // Stage 2: products; the integral product is split in two halves of the sum
  logic signed [P_W-1:0]   prod_p_r;
  logic signed [D_W-1:0]   prod_d_r;
  logic        [ILO_W-1:0] prod_ilo_r;
  logic signed [IHI_W-1:0] prod_ihi_r;

  always_ff @(posedge clk) begin
    if (go[2]) begin
      prod_p_r   <= $signed({1'b0, cfg.gain_prop}) * P_W'(err_r);
      prod_d_r   <= $signed({1'b0, cfg.gain_deriv_step}) * D_W'(derr_r);
      prod_ilo_r <= cfg.gain_integral_step * sum_r[HALF_W-1:0];
      prod_ihi_r <= $signed({1'b0, cfg.gain_integral_step})
                    * IHI_W'($signed(sum_r[SUM_W-1:HALF_W]));
    end
  end

  // Stage 3: proportional plus derivative, and the rebuilt integral term
  logic signed [ACC_W-1:0] pd_r;
  logic signed [ACC_W-1:0] iterm_r;

  always_ff @(posedge clk) begin
    if (go[3]) begin
      pd_r    <= ACC_W'(prod_p_r) + ACC_W'(prod_d_r);
      iterm_r <= (ACC_W'(prod_ihi_r) <<< HALF_W) + $signed({{(ACC_W-ILO_W){1'b0}}, prod_ilo_r});
    end
  end

  // Stage 4: full sum, saturated to 64 bits
  logic signed [ACC_W-1:0] tot;
  logic signed [63:0]      u_nxt;
  logic signed [63:0]      u_r;

  always_comb begin
    tot = pd_r + iterm_r;
    if (tot[ACC_W-1:63] == '0 || tot[ACC_W-1:63] == '1) begin
      u_nxt = tot[63:0];
    end else begin
      u_nxt = tot[ACC_W-1] ? U_MIN : U_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (go[4]) u_r <= u_nxt;
  end

  // Stage 5: direction, integer part, raw saturation and speed clamp
  logic               neg;
  logic [63:0]        mag;
  logic [47:0]        ipart;
  logic [RAW_W-1:0]   raw_nxt;
  logic [SPEED_W-1:0] speed_nxt;
  logic [SPEED_W-1:0] speed_r;
  logic [RAW_W-1:0]   raw_r;
  logic               fwd_r;

  always_comb begin
    neg   = u_r[63];
    mag   = neg ? (~u_r + 64'd1) : u_r;
    ipart = mag[63:16];
    if (!neg) begin
      raw_nxt = (|ipart[47:31]) ? RAW_MAX : {1'b0, ipart[30:0]};
    end else if ((|ipart[47:32]) || (ipart[31] && (|ipart[30:0]))) begin
      raw_nxt = RAW_MIN;
    end else begin
      raw_nxt = ~ipart[31:0] + 32'd1;
    end
    // ceiling test comes before the floor
    priority if ((|ipart[47:SPEED_W]) || (ipart[SPEED_W-1:0] > cfg.speed_ceiling)) begin
      speed_nxt = cfg.speed_ceiling;
    end else if (ipart[SPEED_W-1:0] < cfg.speed_floor) begin
      speed_nxt = cfg.speed_floor;
    end else begin
      speed_nxt = ipart[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (go[5]) begin
      fwd_r   <= !neg;
      speed_r <= speed_nxt;
      raw_r   <= raw_nxt;
    end
  end

  assign out_tvalid = vld_r[5];
  assign out_tuser  = fwd_r;
  assign out_tdata  = {1'b0, raw_r, speed_r};

endmodule

`default_nettype wire

[hdl/pdm_cfg_regs.sv]
// ---------------------------------------------------------------------------
// pdm_cfg_regs: controller configuration registers
// Holds the three Q8.16 gains and the speed limits; always ready.
// ---------------------------------------------------------------------------
`default_nettype none

module pdm_cfg_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [pdm_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [pdm_pkg::GAIN_W-1:0] cfg_data,
  output pdm_pkg::cfg_t                  cfg
);
  import pdm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode one write request; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_addr)
        REG_GAIN_PROP:     cfg_nxt.gain_prop          = cfg_data;
        REG_GAIN_INTEGRAL: cfg_nxt.gain_integral_step = cfg_data;
        REG_GAIN_DERIV:    cfg_nxt.gain_deriv_step    = cfg_data;
        REG_SPEED_CEILING: cfg_nxt.speed_ceiling      = cfg_data[SPEED_W-1:0];
        REG_SPEED_FLOOR:   cfg_nxt.speed_floor        = cfg_data[SPEED_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop          <= GAIN_PROP_RST;
      cfg_r.gain_integral_step <= GAIN_INTEGRAL_RST;
      cfg_r.gain_deriv_step    <= GAIN_DERIV_RST;
      cfg_r.speed_ceiling      <= SPEED_CEILING_RST;
      cfg_r.speed_floor        <= SPEED_FLOOR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/pdm_checker.sv]
// ---------------------------------------------------------------------------
// pdm_checker: port-level checks for the PID motor drive
// Watches the result channel over time; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module pdm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tuser
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Forward drive never comes with a negative raw output
  a_fwd_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[38])
    else $error("forward drive with negative output");

  // Reverse drive never comes with a positive raw output
  a_rev_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[38] || out_tdata[38:7] == 32'd0)
    else $error("reverse drive with positive output");

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

endmodule

bind pid_position_motor_drive pdm_checker u_pdm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
